// ----- sv/sensor_frame_crc_converter_defines.svh -----
// ----------------------------------------------------------------------------
// Sensor frame CRC converter: assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC_CONVERTER_DEFINES_SVH
`define SENSOR_FRAME_CRC_CONVERTER_DEFINES_SVH

// check outside reset
`define SFCC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sfcc assertion failed");

// check at every edge, reset included
`define SFCC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sfcc assertion failed");

`endif

// ----- sv/sfcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Sensor frame CRC converter package
// Beat types, register codes, conversion constants and the CRC-8 step.
// ----------------------------------------------------------------------------
package sfcc_pkg;

    localparam int DATA_BYTES_DEF = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_EN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFF   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_OFF    = 2'd3;

    localparam logic [7:0]  CRC_POLY_RST = 8'h31;
    localparam logic        CRC_EN_RST   = 1'b1;
    localparam logic [15:0] STATUS_MASK  = 16'hFFFC;

    localparam logic [14:0]        TEMP_SCALE = 15'd17572;
    localparam logic [14:0]        HUM_SCALE  = 15'd12500;
    localparam logic signed [15:0] TEMP_BASE  = -16'sd4685;
    localparam logic signed [15:0] HUM_BASE   = -16'sd600;

    localparam logic CH_TEMP = 1'b0;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic       channel;
    } t_in_beat;

    typedef struct packed {
        logic               result_channel;
        logic [15:0]        raw_value;
        logic signed [15:0] value_hundredths;
        logic               crc_ok;
    } t_out_beat;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- sv/sfcc_if.sv -----
// ----------------------------------------------------------------------------
// Sensor frame CRC converter channels
// Valid/ready channels for received bytes and converted results.
// ----------------------------------------------------------------------------
interface sfcc_in_if import sfcc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sfcc_out_if import sfcc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/sensor_frame_crc_converter.sv -----
// ----------------------------------------------------------------------------
// Sensor frame CRC converter
// A result passes the stage-1 register, then the output register, after its
// checksum byte is accepted. Throughput: one byte per cycle while results are
// taken; the CRC step and one 16x15 multiply-add each sit in a single stage,
// with a registered output that takes a new beat while the previous one is
// taken. Active-low synchronous reset restores frame state, valids and config.
// ----------------------------------------------------------------------------
module sensor_frame_crc_converter import sfcc_pkg::*; #(
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sfcc_in_if.sink               i_in,
    sfcc_out_if.source            o_out
);

    localparam int POS_W = $clog2(DATA_BYTES + 1);

    logic [7:0]         r_poly;
    logic               r_crc_en;
    logic signed [15:0] r_temp_off;
    logic signed [15:0] r_hum_off;

    logic [POS_W-1:0] r_pos, n_pos, pos_eff;
    logic [7:0]       r_crc, n_crc, crc_base;
    logic [7:0]       r_hi, n_hi, hi_base;
    logic [7:0]       r_lo, n_lo, lo_base;
    logic             r_kind, n_kind, kind_base;
    logic             first, is_data, accept;

    logic        r_v1;
    logic [15:0] r_raw;
    logic        r_kind1;
    logic        r_ok;

    logic      r_ov;
    t_out_beat r_out, n_out;

    logic out_adv, s1_adv;

    logic [30:0]        prod;
    logic signed [17:0] sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly     <= CRC_POLY_RST;
            r_crc_en   <= CRC_EN_RST;
            r_temp_off <= '0;
            r_hum_off  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CRC_POLY: r_poly     <= i_cfg_data[7:0];
                REG_CRC_EN:   r_crc_en   <= i_cfg_data[0];
                REG_TEMP_OFF: r_temp_off <= $signed(i_cfg_data[15:0]);
                REG_HUM_OFF:  r_hum_off  <= $signed(i_cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    assign out_adv    = !r_ov || o_out.ready;
    assign s1_adv     = !r_v1 || out_adv;
    assign i_in.ready = s1_adv;
    assign accept     = i_in.valid && s1_adv;

    always_comb begin
        pos_eff   = i_in.data.frame_start ? '0 : r_pos;
        first     = (pos_eff == '0);
        crc_base  = first ? 8'h00 : r_crc;
        hi_base   = first ? 8'h00 : r_hi;
        lo_base   = first ? 8'h00 : r_lo;
        kind_base = first ? i_in.data.channel : r_kind;
        is_data   = (pos_eff < POS_W'(DATA_BYTES));
        n_pos     = '0;
        n_crc     = r_crc;
        n_hi      = r_hi;
        n_lo      = r_lo;
        n_kind    = kind_base;
        if (is_data) begin
            n_pos = pos_eff + POS_W'(1);
            n_crc = crc8_byte(crc_base, i_in.data.rx_byte, r_poly);
            n_hi  = lo_base;
            n_lo  = i_in.data.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_crc  <= '0;
            r_hi   <= '0;
            r_lo   <= '0;
            r_kind <= 1'b0;
        end else if (accept) begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_hi   <= n_hi;
            r_lo   <= n_lo;
            r_kind <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_adv) begin
            r_v1 <= accept && !is_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !is_data) begin
            r_raw   <= {hi_base, lo_base} & STATUS_MASK;
            r_kind1 <= kind_base;
            r_ok    <= !r_crc_en || (crc_base == i_in.data.rx_byte);
        end
    end

    always_comb begin
        if (r_kind1 == CH_TEMP) begin
            prod = 31'(TEMP_SCALE) * 31'(r_raw);
            sum  = 18'(TEMP_BASE) + $signed({3'b000, prod[30:16]}) + 18'(r_temp_off);
        end else begin
            prod = 31'(HUM_SCALE) * 31'(r_raw);
            sum  = 18'(HUM_BASE) + $signed({3'b000, prod[30:16]}) + 18'(r_hum_off);
        end
        n_out.result_channel = r_kind1;
        n_out.raw_value      = r_raw;
        n_out.crc_ok         = r_ok;
        if (sum > 18'sd32767) begin
            n_out.value_hundredths = 16'sh7FFF;
        end else if (sum < -18'sd32768) begin
            n_out.value_hundredths = 16'sh8000;
        end else begin
            n_out.value_hundredths = sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_adv) begin
            r_ov <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_v1) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

endmodule

// ----- sv/sfcc_checker.sv -----
// ----------------------------------------------------------------------------
// Sensor frame CRC converter checker
// Port-level assertions on result timing, stalls and the raw word.
// ----------------------------------------------------------------------------
`include "sensor_frame_crc_converter_defines.svh"

module sfcc_checker import sfcc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_beat i_out_data
);

    `SFCC_ASSERT_ALWAYS(a_rst_no_out, i_clk, !i_rst_n |=> !i_out_valid)
    `SFCC_ASSERT(a_out_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
    `SFCC_ASSERT(a_raw_status_clear, i_clk, i_rst_n,
        i_out_valid |-> i_out_data.raw_value[1:0] == 2'b00)
    `SFCC_ASSERT(a_out_from_beat, i_clk, i_rst_n,
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))

endmodule

bind sensor_frame_crc_converter sfcc_checker u_sfcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ----- verif/sensor_frame_crc_converter_tb.sv -----
// ----------------------------------------------------------------------------
// Sensor frame CRC converter testbench
// Streams measurement frames (well-formed, broken and noise bytes) through the
// converter under several register settings, predicts CRC verdict, raw word
// and saturated reading per checksum byte, and checks every output beat in
// order while both sides idle at random and the output side holds off once.
// ----------------------------------------------------------------------------
module sensor_frame_crc_converter_tb;
    import sfcc_pkg::*;

    localparam int          FRAME_DATA   = DATA_BYTES_DEF;
    localparam logic        CH_HUM       = 1'b1;
    localparam logic [31:0] TEMP_MULT    = 32'd17572;
    localparam logic [31:0] HUM_MULT     = 32'd12500;
    localparam int          TEMP_OFFSET0 = -4685;
    localparam int          HUM_OFFSET0  = -600;
    localparam int          IDLE_PAD     = 6;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          LIMIT_CYCLES = 200000;
    localparam int          PRINT_CAP    = 100;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sfcc_in_if  in_bus ();
    sfcc_out_if out_bus ();

    sensor_frame_crc_converter DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    logic [7:0]         sh_poly;
    logic               sh_crc_en;
    logic signed [15:0] sh_temp_off;
    logic signed [15:0] sh_hum_off;

    logic [1:0] fr_pos;
    logic [7:0] fr_crc;
    logic [7:0] fr_hi;
    logic [7:0] fr_lo;
    logic       fr_kind;

    t_in_beat  bytes_to_send[$];
    t_out_beat readings_due[$];
    t_out_beat got_beat;
    t_out_beat want_beat;

    int  mismatches;
    int  cycle_cnt;
    int  in_gap_left;
    int  out_wait;
    bit  in_burst;
    bit  out_burst;
    bit  in_force_burst;
    logic holdoff;
    event hold_go;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b,
                                            input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    task automatic predict_reading(input t_in_beat b);
        logic [15:0] raw;
        logic [31:0] prod;
        int          val;
        t_out_beat   r;
        if (b.frame_start || fr_pos > FRAME_DATA) begin
            fr_pos = 0;
        end
        if (fr_pos == 0) begin
            fr_crc  = 8'h00;
            fr_hi   = 8'h00;
            fr_lo   = 8'h00;
            fr_kind = b.channel;
        end
        if (fr_pos < FRAME_DATA) begin
            fr_crc = crc_step(fr_crc, b.rx_byte, sh_poly);
            fr_hi  = fr_lo;
            fr_lo  = b.rx_byte;
            fr_pos = fr_pos + 2'd1;
        end else begin
            fr_pos = 0;
            raw = {fr_hi, fr_lo} & 16'hFFFC;
            if (fr_kind == CH_TEMP) begin
                prod = TEMP_MULT * {16'd0, raw};
                val  = TEMP_OFFSET0 + int'(prod[31:16]) + int'(sh_temp_off);
            end else begin
                prod = HUM_MULT * {16'd0, raw};
                val  = HUM_OFFSET0 + int'(prod[31:16]) + int'(sh_hum_off);
            end
            if (val > 32767) val = 32767;
            if (val < -32768) val = -32768;
            r.result_channel   = fr_kind;
            r.raw_value        = raw;
            r.value_hundredths = 16'(val);
            r.crc_ok           = !sh_crc_en || (fr_crc == b.rx_byte);
            readings_due.push_back(r);
        end
    endtask

    task automatic flag_mismatch(input string field, input int got, input int want);
        if (mismatches < PRINT_CAP) begin
            $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        end
        mismatches++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic start, input logic ch);
        t_in_beat t;
        t.rx_byte     = b;
        t.frame_start = start;
        t.channel     = ch;
        bytes_to_send.push_back(t);
    endtask

    task automatic queue_frame(input logic ch, input logic [7:0] hi, input logic [7:0] lo,
                               input logic start, input bit good);
        logic [7:0] c;
        c = crc_step(crc_step(8'h00, hi, sh_poly), lo, sh_poly);
        if (!good) c = c ^ 8'($urandom_range(1, 255));
        push_byte(hi, start, ch);
        push_byte(lo, 1'b0, 1'($urandom_range(0, 1)));
        push_byte(c, 1'b0, 1'($urandom_range(0, 1)));
    endtask

    task automatic queue_extremes();
        queue_frame(CH_TEMP, 8'hFF, 8'hFF, 1'b1, 1'b1);
        queue_frame(CH_TEMP, 8'h00, 8'h00, 1'b1, 1'b1);
        queue_frame(CH_HUM, 8'hFF, 8'hFF, 1'b1, 1'b1);
        queue_frame(CH_HUM, 8'h00, 8'h00, 1'b1, 1'b0);
    endtask

    task automatic queue_random(input int n);
        int cnt;
        int kind;
        int len;
        cnt = 0;
        while (cnt < n) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                queue_frame(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                            1'($urandom_range(0, 3) != 0), $urandom_range(0, 4) != 0);
                cnt += 3;
            end else if (kind == 8) begin
                push_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                cnt++;
            end else begin
                len = $urandom_range(1, 2);
                push_byte(8'($urandom), 1'b1, 1'($urandom_range(0, 1)));
                if (len == 2) push_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
                cnt += len;
            end
        end
        // close with a clean frame so the next register change lands between frames
        queue_frame(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 1'b1, 1'b1);
    endtask

    task automatic wait_idle();
        while (bytes_to_send.size() != 0 || in_bus.valid || readings_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_CRC_POLY: sh_poly     = value[7:0];
            REG_CRC_EN:   sh_crc_en   = value[0];
            REG_TEMP_OFF: sh_temp_off = value;
            REG_HUM_OFF:  sh_hum_off  = value;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [7:0] poly, input logic en,
                                input logic [15:0] toff, input logic [15:0] hoff);
        wait_idle();
        set_reg(REG_CRC_POLY, {8'h00, poly});
        set_reg(REG_CRC_EN, {15'd0, en});
        set_reg(REG_TEMP_OFF, toff);
        set_reg(REG_HUM_OFF, hoff);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] poly, input logic en, input logic [15:0] toff,
                             input logic [15:0] hoff, input int n, input bit hold);
        program_regs(poly, en, toff, hoff);
        @(negedge clk);
        in_force_burst = hold;
        queue_extremes();
        queue_random(n);
        if (hold) -> hold_go;
        wait_idle();
        @(negedge clk);
        in_force_burst = 1'b0;
    endtask

    initial begin
        holdoff = 1'b0;
        forever begin
            @(hold_go);
            @(posedge clk);
            holdoff <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holdoff <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            in_bus.valid <= 1'b0;
            in_gap_left = 0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                predict_reading(in_bus.data);
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (in_gap_left > 0) begin
                    in_gap_left--;
                    in_bus.valid <= 1'b0;
                end else if (bytes_to_send.size() > 0) begin
                    in_bus.valid <= 1'b1;
                    in_bus.data  <= bytes_to_send.pop_front();
                    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
                    in_gap_left = (in_burst || in_force_burst) ? 0 : $urandom_range(0, 6);
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_bus.ready <= 1'b0;
            out_wait = 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                got_beat = out_bus.data;
                if (readings_due.size() == 0) begin
                    flag_mismatch("beat with none due, raw_value", got_beat.raw_value, -1);
                end else begin
                    want_beat = readings_due.pop_front();
                    if (got_beat.result_channel !== want_beat.result_channel)
                        flag_mismatch("result_channel", got_beat.result_channel,
                                      want_beat.result_channel);
                    if (got_beat.raw_value !== want_beat.raw_value)
                        flag_mismatch("raw_value", got_beat.raw_value, want_beat.raw_value);
                    if (got_beat.value_hundredths !== want_beat.value_hundredths)
                        flag_mismatch("value_hundredths", int'(got_beat.value_hundredths),
                                      int'(want_beat.value_hundredths));
                    if (got_beat.crc_ok !== want_beat.crc_ok)
                        flag_mismatch("crc_ok", got_beat.crc_ok, want_beat.crc_ok);
                end
                if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
                out_wait = out_burst ? 0 : $urandom_range(0, 6);
            end
            if (holdoff) begin
                out_bus.ready <= 1'b0;
            end else if (out_wait > 0) begin
                out_wait--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("** sensor_frame_crc_converter: FAILED **");
            $finish;
        end
    end

    initial begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_CRC_POLY;
        cfg_data       = '0;
        in_bus.valid   = 1'b0;
        in_bus.data    = '0;
        out_bus.ready  = 1'b0;
        mismatches     = 0;
        cycle_cnt      = 0;
        in_burst       = 1'b0;
        out_burst      = 1'b0;
        in_force_burst = 1'b0;
        sh_poly        = CRC_POLY_RST;
        sh_crc_en      = CRC_EN_RST;
        sh_temp_off    = '0;
        sh_hum_off     = '0;
        fr_pos         = '0;
        fr_crc         = '0;
        fr_hi          = '0;
        fr_lo          = '0;
        fr_kind        = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        queue_frame(CH_TEMP, 8'h00, 8'h00, 1'b1, 1'b1);
        queue_frame(CH_TEMP, 8'hFF, 8'hFF, 1'b1, 1'b1);
        queue_frame(CH_HUM, 8'hFF, 8'hFF, 1'b0, 1'b1);
        queue_frame(CH_HUM, 8'h00, 8'h03, 1'b1, 1'b0);
        // drop a partial frame after one byte, then after two
        push_byte(8'hA5, 1'b1, CH_HUM);
        queue_frame(CH_TEMP, 8'h66, 8'h5C, 1'b1, 1'b1);
        push_byte(8'h12, 1'b1, CH_TEMP);
        push_byte(8'h34, 1'b0, CH_HUM);
        queue_frame(CH_HUM, 8'h80, 8'h00, 1'b1, 1'b1);
        queue_frame(CH_TEMP, 8'h7F, 8'hFE, 1'b1, 1'b1);
        queue_random(250);
        wait_idle();

        run_phase(8'hFF, 1'b1, 16'h7FFF, 16'h8000, 150, 1'b0);
        run_phase(8'h00, 1'b0, 16'h8000, 16'h7FFF, 150, 1'b0);
        run_phase(8'($urandom), 1'b1, 16'($urandom), 16'($urandom), 300, 1'b1);
        run_phase(8'($urandom), 1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                  250, 1'b0);
        run_phase(CRC_POLY_RST, CRC_EN_RST, 16'h0000, 16'h0000, 60, 1'b0);

        if (mismatches == 0) begin
            $display("** sensor_frame_crc_converter: PASSED **");
        end else begin
            $display("** sensor_frame_crc_converter: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sensor_frame_crc_converter.f -----
+incdir+sv
sv/sfcc_pkg.sv
sv/sfcc_if.sv
sv/sensor_frame_crc_converter.sv
sv/sfcc_checker.sv
verif/sensor_frame_crc_converter_tb.sv
